[design/bounded_list_store_unit_assert.svh]
// Assertion macros for the bounded list store unit.
`ifndef BOUNDED_LIST_STORE_UNIT_ASSERT_SVH
`define BOUNDED_LIST_STORE_UNIT_ASSERT_SVH
`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define BLSU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next cycle.
`define BLSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BLSU_ASSERT_ALWAYS(label, prop, msg)
`define BLSU_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[design/bls_pkg.sv]
// Shared widths, command codes and status codes of the bounded list store.
package bls_pkg;

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Command codes
  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_REMOVE     = 3'd4;

  // Status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

endpackage

[design/bounded_list_store_unit.sv]
// Bounded deque of signed 32-bit words with remove-by-value.
//
// Usage: drive command and value and raise start; the word is taken at a
// rising edge where start is high and busy is low. Every command gives one
// result: done is high for exactly one cycle with status and count valid.
// The receiver cannot stall; it must take the result in that cycle.
// Push front/back and pop front/back finish at the accepting edge; done
// is high in the next cycle and busy never rises, so one of these commands
// can be taken every cycle.
// Remove by value scans the stored entries in order through one read port
// of the entry memory (one entry per cycle, registered read) and shifts
// the entries behind the hit forward through the write port in the same
// pass. busy stays high until the last stored entry has been read, and
// done rises at the edge where busy falls.
// A remove on an empty store finishes like a pop, with status empty.
// Reset (synchronous, active high) clears the front pointer, occupancy and
// the control state; the entry memory is not cleared and needs no sweep.
module bounded_list_store_unit #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bls_pkg::CMD_W-1:0]     command,
  input  logic signed [bls_pkg::VALUE_W-1:0] value,
  output logic                          done,
  output logic [bls_pkg::STATUS_W-1:0]  status,
  output logic [bls_pkg::COUNT_W-1:0]   count
);

  `include "bounded_list_store_unit_assert.svh"

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // Controller states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  // Slot of a position counted from the front, wrapped at DEPTH
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(pos);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Entry memory: one write port, one registered read port
  logic signed [bls_pkg::VALUE_W-1:0] mem [DEPTH];
  logic signed [bls_pkg::VALUE_W-1:0] rdata;
  logic [IDX_W-1:0]                   raddr;
  logic [IDX_W-1:0]                   waddr;
  logic signed [bls_pkg::VALUE_W-1:0] wdata;
  logic                               we;

  // Control and payload registers
  logic                               state, state_next;
  logic [IDX_W-1:0]                   front, front_next;
  logic [CNT_W-1:0]                   occ, occ_next;
  logic [CNT_W-1:0]                   cpos, cpos_next;
  logic                               found, found_next;
  logic signed [bls_pkg::VALUE_W-1:0] key, key_next;
  logic                               done_next;
  logic [bls_pkg::STATUS_W-1:0]       status_next;

  logic [IDX_W-1:0]                   front_dec;
  logic [IDX_W-1:0]                   front_inc;
  logic                               hit_now;
  logic                               is_full;
  logic                               store_empty;

  // Terms for the checks
  logic                               take;
  logic                               remove_go;
  logic                               full_push;
  logic                               full_refused;

  assign busy        = (state == S_SCAN);
  assign front_dec   = (front == '0) ? LAST_IDX : front - IDX_W'(1);
  assign front_inc   = (front == LAST_IDX) ? '0 : front + IDX_W'(1);
  assign is_full     = (occ == DEPTH_C);
  assign store_empty = (occ == '0);
  assign hit_now     = found || (rdata == key);

  // Next-state logic
  always_comb begin
    state_next  = state;
    front_next  = front;
    occ_next    = occ;
    cpos_next   = cpos;
    found_next  = found;
    key_next    = key;
    done_next   = 1'b0;
    status_next = status;
    we          = 1'b0;
    waddr       = slot_of(front, cpos - CNT_W'(1));
    wdata       = rdata;
    raddr       = slot_of(front, cpos + CNT_W'(1));
    case (state)
      S_IDLE: begin
        // position 0 is read so a remove scan can start next cycle
        raddr = front;
        wdata = value;
        if (start) begin
          done_next   = 1'b1;
          status_next = bls_pkg::ST_OK;
          case (command)
            bls_pkg::CMD_PUSH_FRONT: begin
              if (is_full) begin
                status_next = bls_pkg::ST_FULL;
              end else begin
                front_next = front_dec;
                we         = 1'b1;
                waddr      = front_dec;
                occ_next   = occ + CNT_W'(1);
              end
            end
            bls_pkg::CMD_PUSH_BACK: begin
              if (is_full) begin
                status_next = bls_pkg::ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = slot_of(front, occ);
                occ_next = occ + CNT_W'(1);
              end
            end
            bls_pkg::CMD_POP_FRONT: begin
              if (store_empty) begin
                status_next = bls_pkg::ST_EMPTY;
              end else begin
                front_next = front_inc;
                occ_next   = occ - CNT_W'(1);
              end
            end
            bls_pkg::CMD_POP_BACK: begin
              if (store_empty) begin
                status_next = bls_pkg::ST_EMPTY;
              end else begin
                occ_next = occ - CNT_W'(1);
              end
            end
            bls_pkg::CMD_REMOVE: begin
              if (store_empty) begin
                status_next = bls_pkg::ST_EMPTY;
              end else begin
                done_next  = 1'b0;
                state_next = S_SCAN;
                cpos_next  = '0;
                found_next = 1'b0;
                key_next   = value;
              end
            end
            default: begin
              // unused codes leave the store as it is
            end
          endcase
        end
      end
      S_SCAN: begin
        // rdata holds position cpos; once the hit is behind us, shift forward
        we = found;
        if (cpos == occ - CNT_W'(1)) begin
          state_next  = S_IDLE;
          done_next   = 1'b1;
          status_next = hit_now ? bls_pkg::ST_OK : bls_pkg::ST_NOTFOUND;
          occ_next    = hit_now ? occ - CNT_W'(1) : occ;
        end else begin
          cpos_next  = cpos + CNT_W'(1);
          found_next = hit_now;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      occ   <= '0;
      done  <= 1'b0;
      found <= 1'b0;
      cpos  <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      occ   <= occ_next;
      done  <= done_next;
      found <= found_next;
      cpos  <= cpos_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key    <= key_next;
    status <= status_next;
    count  <= bls_pkg::COUNT_W'(occ_next);
  end

  // Checks
  assign take         = start && !busy;
  assign remove_go    = take && (command == bls_pkg::CMD_REMOVE) && !store_empty;
  assign full_push    = take && is_full && ((command == bls_pkg::CMD_PUSH_FRONT) ||
                                            (command == bls_pkg::CMD_PUSH_BACK));
  assign full_refused = done && (status == bls_pkg::ST_FULL) && is_full;

  `BLSU_ASSERT_ALWAYS(a_occ_bound, occ <= DEPTH_C, "occupancy above depth")
  `BLSU_ASSERT_ALWAYS(a_done_idle, !(done && busy), "result strobe during a scan")
  `BLSU_ASSERT_ALWAYS(a_scan_pos, !busy || (cpos < occ), "scan position past last entry")
  `BLSU_ASSERT_NEXT(a_remove_scan, remove_go, busy && !done, "remove did not start a scan")
  `BLSU_ASSERT_NEXT(a_full_status, full_push, full_refused, "push into full store not refused")

endmodule

[sim/bls_deque_monitor.sv]
// Deque monitor: tracks accepted command words, predicts status and count, compares results.
module bls_deque_monitor #(
  parameter int DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic [bls_pkg::CMD_W-1:0]          command,
  input  logic signed [bls_pkg::VALUE_W-1:0] value,
  input  logic                               done,
  input  logic [bls_pkg::STATUS_W-1:0]       status,
  input  logic [bls_pkg::COUNT_W-1:0]        count,
  output int                                 mismatches,
  output int                                 pending
);

  typedef struct packed {
    bls_pkg::status_t              status;
    logic [bls_pkg::COUNT_W-1:0]   count;
  } deque_result_t;

  // Contents of the deque, front at index 0
  logic signed [bls_pkg::VALUE_W-1:0] held_values[$];
  deque_result_t                      expected_results[$];
  deque_result_t                      oldest;
  deque_result_t                      predicted;

  // Apply one command word to the shadow deque and return its result
  function automatic deque_result_t apply_command(
    input bls_pkg::cmd_t                      cmd,
    input logic signed [bls_pkg::VALUE_W-1:0] v
  );
    deque_result_t r;
    int            hit;
    r.status = bls_pkg::ST_OK;
    hit      = -1;
    case (cmd)
      bls_pkg::CMD_PUSH_FRONT: begin
        if (held_values.size() >= DEPTH) r.status = bls_pkg::ST_FULL;
        else held_values.push_front(v);
      end
      bls_pkg::CMD_PUSH_BACK: begin
        if (held_values.size() >= DEPTH) r.status = bls_pkg::ST_FULL;
        else held_values.push_back(v);
      end
      bls_pkg::CMD_POP_FRONT: begin
        if (held_values.size() == 0) r.status = bls_pkg::ST_EMPTY;
        else void'(held_values.pop_front());
      end
      bls_pkg::CMD_POP_BACK: begin
        if (held_values.size() == 0) r.status = bls_pkg::ST_EMPTY;
        else void'(held_values.pop_back());
      end
      bls_pkg::CMD_REMOVE: begin
        if (held_values.size() == 0) begin
          r.status = bls_pkg::ST_EMPTY;
        end else begin
          // first match counted from the front
          for (int i = 0; i < held_values.size(); i++) begin
            if (held_values[i] == v) begin
              hit = i;
              break;
            end
          end
          if (hit < 0) r.status = bls_pkg::ST_NOTFOUND;
          else held_values.delete(hit);
        end
      end
      default: ; // unused codes leave the deque alone
    endcase
    r.count = bls_pkg::COUNT_W'(held_values.size());
    return r;
  endfunction

  // Result check first (it belongs to an older word), then capture a new word
  always @(posedge clk) begin
    if (rst) begin
      held_values.delete();
      expected_results.delete();
    end else begin
      if (done === 1'b1) begin
        if (expected_results.size() == 0) begin
          $error("result with no word pending: status %0d count %0d", status, count);
          mismatches++;
        end else begin
          oldest = expected_results.pop_front();
          if (status !== oldest.status) begin
            $error("status mismatch: expected %0d, got %0d", oldest.status, status);
            mismatches++;
          end
          if (count !== oldest.count) begin
            $error("count mismatch: expected %0d, got %0d", oldest.count, count);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        predicted = apply_command(command, value);
        expected_results.push_back(predicted);
      end
    end
    pending = expected_results.size();
  end

endmodule

[sim/tb_bounded_list_store_unit.sv]
// Testbench top: drives command words into the deque unit and reports the verdict.
module tb_bounded_list_store_unit;

  localparam int DEPTH = 16;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int SEGMENT_LEN = 40;
  localparam logic signed [bls_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [bls_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  // Codes the unit must ignore
  localparam bls_pkg::cmd_t CMD_RSVD_FIRST = 3'd5;
  localparam bls_pkg::cmd_t CMD_RSVD_LAST  = 3'd7;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               start = 1'b0;
  logic [bls_pkg::CMD_W-1:0]          command = bls_pkg::CMD_PUSH_FRONT;
  logic signed [bls_pkg::VALUE_W-1:0] value = '0;
  logic                               busy;
  logic                               done;
  logic [bls_pkg::STATUS_W-1:0]       status;
  logic [bls_pkg::COUNT_W-1:0]        count;
  int                                 mismatches;
  int                                 pending;

  bounded_list_store_unit #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .value(value),
    .done(done), .status(status), .count(count)
  );

  bls_deque_monitor #(.DEPTH(DEPTH)) u_monitor (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .value(value),
    .done(done), .status(status), .count(count),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Present one word and hold it until the unit takes it
  task automatic issue(input bls_pkg::cmd_t c, input logic signed [bls_pkg::VALUE_W-1:0] v);
    start   <= 1'b1;
    command <= c;
    value   <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random idle cycles between words, with noise on the payload
  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start   <= 1'b0;
      command <= bls_pkg::cmd_t'($urandom);
      value   <= $urandom;
      @(posedge clk);
    end
  endtask

  // Mostly a small pool so removes hit, with duplicates
  function automatic logic signed [bls_pkg::VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(7);
    if (r < 80) begin
      case ($urandom_range(3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  // push_bias steers the fill level so full and empty both get visited
  function automatic bls_pkg::cmd_t pick_command(input int push_bias);
    int r;
    r = $urandom_range(99);
    if (r < 3) return bls_pkg::cmd_t'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST));
    if (r < 25) return bls_pkg::CMD_REMOVE;
    if ($urandom_range(99) < push_bias)
      return $urandom_range(1) ? bls_pkg::CMD_PUSH_BACK : bls_pkg::CMD_PUSH_FRONT;
    return $urandom_range(1) ? bls_pkg::CMD_POP_BACK : bls_pkg::CMD_POP_FRONT;
  endfunction

  initial begin
    int                                 idle_pct;
    int                                 push_bias;
    logic signed [bls_pkg::VALUE_W-1:0] v;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, reserved codes, fill to full with extremes, refused pushes, removes, pops
    issue(bls_pkg::CMD_POP_FRONT, VAL_MAX);
    issue(bls_pkg::CMD_POP_BACK, VAL_MIN);
    issue(bls_pkg::CMD_REMOVE, 0);
    issue(CMD_RSVD_FIRST, -1);
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0: v = VAL_MIN;
        1: v = VAL_MAX;
        2: v = -1;
        3: v = 0;
        default: v = (i % 4 == 0) ? 0 : $urandom;
      endcase
      issue((i % 2 == 1) ? bls_pkg::CMD_PUSH_BACK : bls_pkg::CMD_PUSH_FRONT, v);
    end
    issue(bls_pkg::CMD_PUSH_FRONT, 1);
    issue(bls_pkg::CMD_PUSH_BACK, 2);
    issue(CMD_RSVD_LAST, 3);
    issue(bls_pkg::CMD_REMOVE, 32'sh1234_5678);
    issue(bls_pkg::CMD_REMOVE, 0);       // duplicates present: first one from the front goes
    issue(bls_pkg::CMD_REMOVE, VAL_MAX);
    issue(bls_pkg::CMD_POP_FRONT, 0);
    issue(bls_pkg::CMD_POP_BACK, 0);

    // Random: phase 0 no gaps, 1 sparse sender, 2 no gaps (results cannot stall), 3 light gaps
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 84 : (ph == 3) ? 7 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % SEGMENT_LEN == 0) push_bias = $urandom_range(90, 10);
        issue(pick_command(push_bias), pick_value());
        idle_gap(idle_pct);
      end
    end
    start <= 1'b0;

    // Drain, then allow for a late stray strobe
    while (pending != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
